>>> hw/rtl/tbs_pkg.sv
`default_nettype none

package tbs_pkg;

    localparam int TIME_W     = 40;
    localparam int COUNT_W    = 16;
    localparam int REC_W      = 31;
    localparam int BKT_W      = 32;
    localparam int SLOT_SEC_W = 17;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SECONDS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RECORDS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REC_LIMIT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT     = 8'd3;

    localparam logic [SLOT_SEC_W-1:0] SLOT_SECONDS_RST   = 17'd600;
    localparam logic [LIMIT_W-1:0]    TARGET_RECORDS_RST = 16'd2000;
    localparam logic [LIMIT_W-1:0]    REC_LIMIT_RST      = 16'd3000;
    localparam logic [LIMIT_W-1:0]    SLOT_LIMIT_RST     = 16'd256;

    // Result kinds.
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_DESC   = 1'b1;

    typedef struct packed {
        logic [SLOT_SEC_W-1:0] slot_seconds;
        logic [LIMIT_W-1:0]    target_records;
        logic [LIMIT_W-1:0]    rec_limit;
        logic [LIMIT_W-1:0]    slot_limit;
    } tbs_cfg_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] timestamp;
        logic [REC_W-1:0]         rec_id;
        logic                     final_point;
    } tbs_in_t;

    // A point after slot classification, as held in the hand-off queue.
    typedef struct packed {
        logic signed [TIME_W-1:0] timestamp;
        logic signed [TIME_W-1:0] slot;
        logic [REC_W-1:0]         rec_id;
        logic                     final_point;
    } tbs_item_t;

    typedef struct packed {
        logic                     kind;
        logic [REC_W-1:0]         record_out;
        logic [BKT_W-1:0]         bucket_index;
        logic signed [TIME_W-1:0] first_time;
        logic signed [TIME_W-1:0] last_time;
        logic [COUNT_W-1:0]       records_in_bucket;
        logic [COUNT_W-1:0]       slots_in_bucket;
        logic signed [TIME_W-1:0] first_slot;
        logic signed [TIME_W-1:0] last_slot;
        logic [BKT_W-1:0]         forced_splits;
        logic                     run_end;
    } tbs_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/tbs_front.sv
`default_nettype none

module tbs_front
    import tbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tbs_cfg_t  cfg,
    input  wire logic      push,
    output logic           full,
    input  wire tbs_in_t   in_item,
    output logic           q_push,
    input  wire logic      q_full,
    output tbs_item_t      q_item
);

    localparam int STEP_W = $clog2(TIME_W);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_FIX  = 2'd2;
    localparam logic [1:0] F_OUT  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TIME_W-1:0]     quo_reg, quo_next;
    logic [SLOT_SEC_W-1:0] rem_reg, rem_next;
    logic [SLOT_SEC_W-1:0] div_reg, div_next;
    logic                  neg_reg, neg_next;
    tbs_item_t             item_reg, item_next;

    logic [SLOT_SEC_W:0]   shifted;
    logic [SLOT_SEC_W:0]   diff;
    logic                  ge;
    logic [TIME_W-1:0]     ts_u;

    assign ts_u    = $unsigned(in_item.timestamp);
    assign shifted = {rem_reg, quo_reg[TIME_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    assign full   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_OUT);
    assign q_item = item_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        item_next  = item_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    // Divide the magnitude, then fix up the sign toward minus infinity.
                    neg_next              = ts_u[TIME_W-1];
                    quo_next              = ts_u[TIME_W-1] ? (~ts_u + 1'b1) : ts_u;
                    rem_next              = '0;
                    div_next              = (cfg.slot_seconds == '0) ? SLOT_SEC_W'(1)
                                                                     : cfg.slot_seconds;
                    step_next             = '0;
                    item_next.timestamp   = in_item.timestamp;
                    item_next.rec_id      = in_item.rec_id;
                    item_next.final_point = in_item.final_point;
                    state_next            = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next  = ge ? diff[SLOT_SEC_W-1:0] : shifted[SLOT_SEC_W-1:0];
                quo_next  = {quo_reg[TIME_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(TIME_W - 1))
                begin
                    state_next = F_FIX;
                end
            end
            F_FIX:
            begin
                if (!neg_reg)
                begin
                    item_next.slot = $signed(quo_reg);
                end
                else if (rem_reg != '0)
                begin
                    item_next.slot = $signed(~quo_reg);
                end
                else
                begin
                    item_next.slot = $signed(~quo_reg + 1'b1);
                end
                state_next = F_OUT;
            end
            F_OUT:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/tbs_queue.sv
`default_nettype none

module tbs_queue
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_push,
    input  wire tbs_item_t q_item,
    output logic           q_full,
    input  wire logic      q_pop,
    output tbs_item_t      q_head,
    output logic           q_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tbs_item_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign wr_en   = q_push && !q_full;
    assign rd_en   = q_pop && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= q_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tbs_back.sv
`default_nettype none

module tbs_back
    import tbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tbs_cfg_t  cfg,
    input  wire tbs_item_t q_head,
    input  wire logic      q_empty,
    output logic           q_pop,
    output logic           empty,
    input  wire logic      pop,
    output tbs_out_t       result
);

    localparam logic [1:0] B_IDLE   = 2'd0;
    localparam logic [1:0] B_TEST   = 2'd1;
    localparam logic [1:0] B_ASSIGN = 2'd2;
    localparam logic [1:0] B_FINAL  = 2'd3;

    localparam logic [COUNT_W-1:0] CNT_MAX   = '1;
    localparam logic [BKT_W-1:0]   SPLIT_MAX = '1;

    logic [1:0]               state_reg, state_next;
    tbs_item_t                item_reg, item_next;
    logic                     open_reg, open_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [COUNT_W-1:0]       slots_reg, slots_next;
    logic signed [TIME_W-1:0] start_reg, start_next;
    logic signed [TIME_W-1:0] end_reg, end_next;
    logic signed [TIME_W-1:0] first_slot_reg, first_slot_next;
    logic signed [TIME_W-1:0] last_slot_reg, last_slot_next;
    logic [BKT_W-1:0]         bkt_reg, bkt_next;
    logic [BKT_W-1:0]         split_reg, split_next;
    logic                     out_valid_reg, out_valid_next;
    tbs_out_t                 out_reg, out_next;

    logic [LIMIT_W-1:0]       eff_tgt;
    logic [LIMIT_W-1:0]       eff_max;
    logic [LIMIT_W-1:0]       eff_slots;
    logic                     differs;
    logic                     full_hit;
    logic                     close_hit;
    logic                     out_free;
    logic                     do_assign;
    tbs_out_t                 desc_w;

    assign eff_tgt   = (cfg.target_records == '0) ? LIMIT_W'(1) : cfg.target_records;
    assign eff_max   = (cfg.rec_limit > eff_tgt) ? cfg.rec_limit : eff_tgt;
    assign eff_slots = (cfg.slot_limit == '0) ? LIMIT_W'(1) : cfg.slot_limit;

    assign differs   = (item_reg.slot != last_slot_reg);
    assign full_hit  = (count_reg >= eff_max);
    assign close_hit = open_reg
                       && (full_hit
                           || (differs && ((slots_reg >= eff_slots) || (count_reg >= eff_tgt))));

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        desc_w                   = '0;
        desc_w.kind              = KIND_DESC;
        desc_w.bucket_index      = bkt_reg;
        desc_w.first_time        = start_reg;
        desc_w.last_time         = end_reg;
        desc_w.records_in_bucket = count_reg;
        desc_w.slots_in_bucket   = slots_reg;
        desc_w.first_slot        = first_slot_reg;
        desc_w.last_slot         = last_slot_reg;
        desc_w.forced_splits     = split_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        open_next       = open_reg;
        count_next      = count_reg;
        slots_next      = slots_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        first_slot_next = first_slot_reg;
        last_slot_next  = last_slot_reg;
        bkt_next        = bkt_reg;
        split_next      = split_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_next        = out_reg;
        q_pop           = 1'b0;
        do_assign       = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_head;
                    state_next = B_TEST;
                end
            end
            B_TEST:
            begin
                if (out_free)
                begin
                    if (close_hit)
                    begin
                        // A full bucket closing inside one slot is a forced split.
                        if (full_hit && !differs && (split_reg != SPLIT_MAX))
                        begin
                            split_next = split_reg + 1'b1;
                        end
                        out_next               = desc_w;
                        out_next.forced_splits = split_next;
                        out_valid_next         = 1'b1;
                        open_next              = 1'b0;
                        bkt_next               = bkt_reg + 1'b1;
                        state_next             = B_ASSIGN;
                    end
                    else
                    begin
                        do_assign = 1'b1;
                    end
                end
            end
            B_ASSIGN:
            begin
                if (out_free)
                begin
                    do_assign = 1'b1;
                end
            end
            B_FINAL:
            begin
                if (out_free)
                begin
                    out_next         = desc_w;
                    out_next.run_end = 1'b1;
                    out_valid_next   = 1'b1;
                    open_next        = 1'b0;
                    count_next       = '0;
                    slots_next       = '0;
                    bkt_next         = '0;
                    split_next       = '0;
                    state_next       = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (do_assign)
        begin
            if (!open_reg)
            begin
                open_next       = 1'b1;
                count_next      = COUNT_W'(1);
                slots_next      = COUNT_W'(1);
                start_next      = item_reg.timestamp;
                first_slot_next = item_reg.slot;
                last_slot_next  = item_reg.slot;
            end
            else
            begin
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (differs)
                begin
                    if (slots_reg != CNT_MAX)
                    begin
                        slots_next = slots_reg + 1'b1;
                    end
                    last_slot_next = item_reg.slot;
                end
            end
            end_next              = item_reg.timestamp;
            out_next              = '0;
            out_next.kind         = KIND_ASSIGN;
            out_next.record_out   = item_reg.rec_id;
            out_next.bucket_index = bkt_reg;
            out_next.run_end      = !item_reg.final_point;
            out_valid_next        = 1'b1;
            state_next            = item_reg.final_point ? B_FINAL : B_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            open_reg       <= 1'b0;
            count_reg      <= '0;
            slots_reg      <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            first_slot_reg <= '0;
            last_slot_reg  <= '0;
            bkt_reg        <= '0;
            split_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            open_reg       <= open_next;
            count_reg      <= count_next;
            slots_reg      <= slots_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            first_slot_reg <= first_slot_next;
            last_slot_reg  <= last_slot_next;
            bkt_reg        <= bkt_next;
            split_reg      <= split_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/time_bucket_segmenter_top.sv
`default_nettype none

// Time bucket segmenter. Points sorted by timestamp arrive through a queue-style
// port (push/full) and are grouped into buckets; every point yields one record
// assignment, and every bucket that closes yields a descriptor, all delivered in
// order through a queue-style result port (empty/pop). A point causes one to three
// results, and the last result of each point carries run_end. The front end maps
// each timestamp to its slot with a radix-2 divider that retires one quotient bit
// per cycle. A point passes through an accept step, 40 divide steps, a sign
// fix-up and a hand-off into the queue, and the front end takes no new point
// until that hand-off is done. The back end applies the bucket rules and emits
// the results of each point; a QUEUE_DEPTH-entry queue between the
// two halves and the result register let either side stall without stopping the
// other. Configuration registers (slot length, target records, maximum records,
// maximum slots) are written through cfg_write/cfg_index/cfg_data and should only
// be changed while no point is in flight; unknown indexes are ignored, and zero
// values for slot length, target records and maximum slots behave as one.
module time_bucket_segmenter_top
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire tbs_in_t               in_item,
    output logic                       empty,
    input  wire logic                  pop,
    output tbs_out_t                   result,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    tbs_cfg_t  cfg_reg, cfg_next;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    tbs_item_t q_item;
    tbs_item_t q_head;

    // Register writes take effect at the next edge; there is no read-back.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SLOT_SECONDS:   cfg_next.slot_seconds   = cfg_data;
                CFG_TARGET_RECORDS: cfg_next.target_records = cfg_data[LIMIT_W-1:0];
                CFG_REC_LIMIT:      cfg_next.rec_limit      = cfg_data[LIMIT_W-1:0];
                CFG_SLOT_LIMIT:     cfg_next.slot_limit     = cfg_data[LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_seconds   <= SLOT_SECONDS_RST;
            cfg_reg.target_records <= TARGET_RECORDS_RST;
            cfg_reg.rec_limit      <= REC_LIMIT_RST;
            cfg_reg.slot_limit     <= SLOT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: takes one point and works out its slot.
    tbs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_item  (q_item)
    );

    // Hand-off queue of classified points.
    tbs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_item  (q_item),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    // Back end: bucket state and result sequencing.
    tbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // The back end only draws from the queue when it holds a point.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    // A closed bucket always holds at least one point.
    a_desc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_DESC)) |->
            ((result.records_in_bucket != '0) && (result.slots_in_bucket != '0)))
        else $error("descriptor for an empty bucket");

    // Assignments carry no bucket summary.
    a_assign_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_ASSIGN)) |->
            ((result.records_in_bucket == '0) && (result.forced_splits == '0)
             && (result.first_time == '0) && (result.last_slot == '0)))
        else $error("assignment with descriptor fields set");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

// Bench for the time bucket segmenter.
//
// Points go in through the push/full side and results come back through the
// empty/pop side. Each accepted point is run through a bucket predictor kept in
// this module, and the results it yields are queued in order. Every result
// transfer is compared, field by field, with the oldest queued result.
//
// The stimulus starts with a short table of directed points and register
// loads. Where a row's results are plain to see (first point after reset,
// time extremes, the all-zero registers), the row carries its results typed
// in and those are checked instead of the predicted ones. After the table, the
// random part runs through several register settings, both extremes among
// them, and sends mostly well-formed streams (nondecreasing times ending with
// a final point) with some unsorted noise mixed in.
module tb;
    import tbs_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 4;
    localparam int     RAND_ITEMS    = 450;
    localparam int     RAND_PHASES   = 6;
    // Cycles to let pass before a register load once every result has come
    // back, and after the last result at the end of the run.
    localparam int     SETTLE_CYCLES = 8;
    localparam int     DRAIN_CYCLES  = 100;
    // A point's front-end pass, one sender gap and up to three receiver stalls
    // can stack up for each point, so this bound sits several times above
    // any correct run of about 500 points.
    localparam int     CYCLE_LIMIT   = 3000000;
    localparam int     MAX_REPORTS   = 40;
    localparam longint TS_MAX        = (64'sd1 <<< (TIME_W - 1)) - 1;
    localparam longint TS_MIN        = -TS_MAX - 1;
    localparam longint COUNT_SAT     = (64'sd1 <<< COUNT_W) - 1;
    localparam int     SLOT_SEC_TOP  = 86400;
    localparam int     IDX_TOP       = (1 << CFG_IDX_W) - 1;
    localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;

    typedef enum logic {ROW_POINT, ROW_CONFIG} row_kind_t;

    // One row of the directed table: either a register load or a point,
    // optionally with the results it must produce typed in.
    typedef struct {
        row_kind_t kind;
        tbs_cfg_t  cfg;
        tbs_in_t   pt;
        int        n_typed;
        tbs_out_t  typed [3];
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    tbs_in_t               in_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    tbs_out_t              result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    time_bucket_segmenter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register values as the block should hold them.
    tbs_cfg_t cfg_model = '{
        slot_seconds:   SLOT_SECONDS_RST,
        target_records: TARGET_RECORDS_RST,
        rec_limit:      REC_LIMIT_RST,
        slot_limit:     SLOT_LIMIT_RST
    };

    // Open bucket as the block should hold it.
    logic             seg_open = 1'b0;
    longint           seg_count = 0;
    longint           seg_slots = 0;
    longint           seg_first_t = 0;
    longint           seg_last_t = 0;
    longint           seg_first_s = 0;
    longint           seg_last_s = 0;
    logic [BKT_W-1:0] seg_number = '0;
    logic [BKT_W-1:0] seg_splits = '0;

    tbs_out_t  point_results[$];     // results of the point just accepted
    tbs_out_t  typed_results[$];     // typed-in results for the next point
    tbs_out_t  awaited_segments[$];  // results still to come back, oldest first
    plan_row_t plan[$];

    int n_errors = 0;
    int n_transfers = 0;
    int cycle_count = 0;
    int rx_hold = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    // Gap length for either side: mostly none or short, now and then long.
    // In a steady stretch there is no gap at all.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(40, 250);
    endfunction

    function automatic longint rand_time();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return longint'({{(64 - TIME_W){raw[TIME_W-1]}}, raw[TIME_W-1:0]});
    endfunction

    // Slot number: the quotient rounds toward minus infinity, so negative
    // times that are not a multiple of the slot length fall one slot lower.
    function automatic longint slot_of(input longint ts, input longint len);
        longint q;
        q = ts / len;
        if ((ts % len) != 0 && ts < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic tbs_out_t assignment_of(input logic [REC_W-1:0] rec,
                                               input logic [BKT_W-1:0] bkt,
                                               input logic last);
        tbs_out_t r;
        r = '0;
        r.kind = KIND_ASSIGN;
        r.record_out = rec;
        r.bucket_index = bkt;
        r.run_end = last;
        return r;
    endfunction

    function automatic tbs_out_t descriptor_of(input logic [BKT_W-1:0] bkt,
                                               input longint ft, input longint lt,
                                               input longint nrec, input longint nslot,
                                               input longint fs, input longint ls,
                                               input logic [BKT_W-1:0] splits,
                                               input logic last);
        tbs_out_t r;
        r = '0;
        r.kind = KIND_DESC;
        r.bucket_index = bkt;
        r.first_time = ft[TIME_W-1:0];
        r.last_time = lt[TIME_W-1:0];
        r.records_in_bucket = nrec[COUNT_W-1:0];
        r.slots_in_bucket = nslot[COUNT_W-1:0];
        r.first_slot = fs[TIME_W-1:0];
        r.last_slot = ls[TIME_W-1:0];
        r.forced_splits = splits;
        r.run_end = last;
        return r;
    endfunction

    // Bucket predictor. Works out the results of one accepted point into
    // point_results and moves the open bucket forward.
    task automatic segment_point(input tbs_in_t pt);
        longint ts;
        longint len;
        longint tgt;
        longint cap;
        longint slot_lim;
        longint slot;
        bit     differs;
        bit     close;
        ts = longint'({{(64 - TIME_W){pt.timestamp[TIME_W-1]}}, pt.timestamp});
        len = (cfg_model.slot_seconds == 0) ? 64'sd1 : longint'(cfg_model.slot_seconds);
        tgt = (cfg_model.target_records == 0) ? 64'sd1 : longint'(cfg_model.target_records);
        cap = (longint'(cfg_model.rec_limit) > tgt) ? longint'(cfg_model.rec_limit) : tgt;
        slot_lim = (cfg_model.slot_limit == 0) ? 64'sd1 : longint'(cfg_model.slot_limit);
        slot = slot_of(ts, len);
        point_results.delete();

        // The close test runs against the new point's slot. A full bucket
        // always closes; if the slot did not move, that close is a forced
        // split. Otherwise the bucket closes on a slot change once it has
        // reached the distinct-slot limit or the target count.
        if (seg_open)
        begin
            differs = (slot != seg_last_s);
            close = 1'b0;
            if (seg_count >= cap)
            begin
                close = 1'b1;
                if (!differs && seg_splits != '1)
                    seg_splits = seg_splits + 1;
            end
            else if (seg_slots >= slot_lim && differs)
                close = 1'b1;
            else if (seg_count >= tgt && differs)
                close = 1'b1;
            if (close)
            begin
                point_results.insert(point_results.size(),
                                     descriptor_of(seg_number, seg_first_t, seg_last_t,
                                                   seg_count, seg_slots, seg_first_s,
                                                   seg_last_s, seg_splits, 1'b0));
                seg_open = 1'b0;
                seg_number = seg_number + 1;
            end
        end

        if (!seg_open)
        begin
            seg_open = 1'b1;
            seg_count = 1;
            seg_slots = 1;
            seg_first_t = ts;
            seg_last_t = ts;
            seg_first_s = slot;
            seg_last_s = slot;
        end
        else
        begin
            // Counts saturate; a distinct slot is any change from the
            // previous point's slot, even going backward.
            if (seg_count < COUNT_SAT)
                seg_count = seg_count + 1;
            if (slot != seg_last_s)
            begin
                if (seg_slots < COUNT_SAT)
                    seg_slots = seg_slots + 1;
                seg_last_s = slot;
            end
            seg_last_t = ts;
        end

        point_results.insert(point_results.size(),
                             assignment_of(pt.rec_id, seg_number, 1'b0));

        // A final point closes the last bucket and starts a new stream, with
        // bucket numbering and the forced split count back at zero.
        if (pt.final_point)
        begin
            point_results.insert(point_results.size(),
                                 descriptor_of(seg_number, seg_first_t, seg_last_t,
                                               seg_count, seg_slots, seg_first_s,
                                               seg_last_s, seg_splits, 1'b0));
            seg_open = 1'b0;
            seg_count = 0;
            seg_slots = 0;
            seg_number = '0;
            seg_splits = '0;
        end

        point_results[point_results.size() - 1].run_end = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR cycle %0d transfer %0d: %s got %h want %h",
                     cycle_count, n_transfers, what, got, want);
    endtask

    task automatic check_result(input tbs_out_t got);
        tbs_out_t want;
        n_transfers++;
        if (awaited_segments.size() == 0)
        begin
            report_mismatch("unexpected result, kind", got.kind, '0);
            return;
        end
        want = awaited_segments.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", got.kind, want.kind);
        if (got.record_out !== want.record_out)
            report_mismatch("record_out", got.record_out, want.record_out);
        if (got.bucket_index !== want.bucket_index)
            report_mismatch("bucket_index", got.bucket_index, want.bucket_index);
        if (got.first_time !== want.first_time)
            report_mismatch("first_time", got.first_time, want.first_time);
        if (got.last_time !== want.last_time)
            report_mismatch("last_time", got.last_time, want.last_time);
        if (got.records_in_bucket !== want.records_in_bucket)
            report_mismatch("records_in_bucket", got.records_in_bucket,
                            want.records_in_bucket);
        if (got.slots_in_bucket !== want.slots_in_bucket)
            report_mismatch("slots_in_bucket", got.slots_in_bucket, want.slots_in_bucket);
        if (got.first_slot !== want.first_slot)
            report_mismatch("first_slot", got.first_slot, want.first_slot);
        if (got.last_slot !== want.last_slot)
            report_mismatch("last_slot", got.last_slot, want.last_slot);
        if (got.forced_splits !== want.forced_splits)
            report_mismatch("forced_splits", got.forced_splits, want.forced_splits);
        if (got.run_end !== want.run_end)
            report_mismatch("run_end", got.run_end, want.run_end);
    endtask

    // Sends one point after a random gap. The push stays high on return so
    // that a following point can go out on the very next edge. On acceptance
    // the point's results are queued: the typed-in ones if any were staged,
    // else the predicted ones. The predictor runs either way to keep its
    // bucket in step with the block.
    task automatic send_point(input tbs_in_t pt);
        int gap;
        gap = pick_gap(tx_steady);
        if ($urandom_range(0, 99) < 4)
            tx_steady = !tx_steady;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= pt;
        @(posedge clk);
        while (full)
            @(posedge clk);
        segment_point(pt);
        if (typed_results.size() != 0)
        begin
            foreach (typed_results[k])
                awaited_segments.insert(awaited_segments.size(), typed_results[k]);
            typed_results.delete();
        end
        else
        begin
            foreach (point_results[k])
                awaited_segments.insert(awaited_segments.size(), point_results[k]);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Register loads happen only with the block idle: every point sent has
    // had all of its results come back, plus a SETTLE_CYCLES wait to settle.
    // Each load also writes a random index above the last register, which
    // must be ignored.
    task automatic load_config(input tbs_cfg_t c);
        push <= 1'b0;
        while (awaited_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_SLOT_SECONDS, c.slot_seconds);
        write_reg(CFG_TARGET_RECORDS, CFG_DATA_W'(c.target_records));
        write_reg(CFG_REC_LIMIT, CFG_DATA_W'(c.rec_limit));
        write_reg(CFG_SLOT_LIMIT, CFG_DATA_W'(c.slot_limit));
        write_reg(CFG_IDX_W'($urandom_range(CFG_SLOT_LIMIT + 1, IDX_TOP)),
                  CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
        cfg_model = c;
    endtask

    task automatic add_point(input longint ts, input logic [REC_W-1:0] rec,
                             input logic fin);
        plan_row_t row;
        row.kind = ROW_POINT;
        row.cfg = '0;
        row.pt.timestamp = ts[TIME_W-1:0];
        row.pt.rec_id = rec;
        row.pt.final_point = fin;
        row.n_typed = 0;
        plan.insert(plan.size(), row);
    endtask

    // Attaches a typed-in result to the most recent point row.
    task automatic add_result(input tbs_out_t r);
        int last;
        last = plan.size() - 1;
        plan[last].typed[plan[last].n_typed] = r;
        plan[last].n_typed++;
    endtask

    task automatic add_config(input tbs_cfg_t c);
        plan_row_t row;
        row.kind = ROW_CONFIG;
        row.cfg = c;
        row.pt = '0;
        row.n_typed = 0;
        plan.insert(plan.size(), row);
    endtask

    // Settings for the random phases: the top of every range first, then
    // the bottom, then small limits so that buckets close often, with slot
    // lengths from one second up to a full day.
    function automatic tbs_cfg_t rand_config(input int phase);
        tbs_cfg_t c;
        if (phase == 0)
        begin
            c.slot_seconds = SLOT_SEC_W'(SLOT_SEC_TOP);
            c.target_records = LIMIT_TOP;
            c.rec_limit = LIMIT_TOP;
            c.slot_limit = LIMIT_TOP;
        end
        else if (phase == 1)
        begin
            c.slot_seconds = SLOT_SEC_W'(1);
            c.target_records = LIMIT_W'(1);
            c.rec_limit = LIMIT_W'(1);
            c.slot_limit = LIMIT_W'(1);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: c.slot_seconds = '0;
                1: c.slot_seconds = SLOT_SEC_W'($urandom_range(1, 16));
                2: c.slot_seconds = SLOT_SEC_W'($urandom_range(17, 600));
                default: c.slot_seconds = SLOT_SEC_W'($urandom_range(601, SLOT_SEC_TOP));
            endcase
            c.target_records = LIMIT_W'($urandom_range(0, 8));
            c.rec_limit = LIMIT_W'($urandom_range(0, 12));
            c.slot_limit = LIMIT_W'($urandom_range(0, 5));
        end
        return c;
    endfunction

    // One stream of points. A clean stream has nondecreasing times that step
    // within a slot, across a few slots or far ahead, and it ends with a
    // final point. A noisy stream has unsorted random times and final flags
    // at random, so it may run into the next stream.
    task automatic send_stream(input bit noisy, inout int sent);
        int      len;
        int      r;
        longint  ts;
        longint  len_s;
        longint  inc;
        tbs_in_t pt;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 10);
        len_s = (cfg_model.slot_seconds == 0) ? 64'sd1 : longint'(cfg_model.slot_seconds);
        if ($urandom_range(0, 99) < 30)
            ts = longint'($urandom_range(0, 4000)) - 2000;
        else
            ts = rand_time();
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
            begin
                ts = rand_time();
                pt.final_point = ($urandom_range(0, 7) == 0);
            end
            else
            begin
                if (i != 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        inc = 0;
                    else if (r < 60)
                        inc = $urandom_range(0, len_s - 1);
                    else if (r < 90)
                        inc = len_s * $urandom_range(1, 3);
                    else
                        inc = $urandom;
                    ts = ts + inc;
                    if (ts > TS_MAX)
                        ts = TS_MAX;
                end
                pt.final_point = (i == len - 1);
            end
            pt.timestamp = ts[TIME_W-1:0];
            pt.rec_id = REC_W'($urandom);
            send_point(pt);
            sent++;
        end
    endtask

    // Result side. A result transfer happens at an edge where pop is high
    // and empty is low; after each one the receiver may hold pop low for a
    // random stretch, so stalls land between the results of one point as
    // well as between points.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                check_result(result);
                if ($urandom_range(0, 99) < 3)
                    rx_steady = !rx_steady;
                rx_hold = pick_gap(rx_steady);
                if (rx_hold > 0)
                    pop <= 1'b0;
            end
            else if (!pop)
            begin
                if (rx_hold > 0)
                    rx_hold--;
                if (rx_hold == 0)
                    pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout with %0d results still awaited", awaited_segments.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int sent;
        sent = 0;

        // Directed table, reset settings. The first point after reset is
        // also the last of its stream, giving a one-point bucket.
        add_point(0, 0, 1'b1);
        add_result(assignment_of(0, 0, 1'b0));
        add_result(descriptor_of(0, 0, 0, 1, 1, 0, 0, 0, 1'b1));
        // Lowest time twice, first with the highest record id, then the highest time.
        add_point(TS_MIN, {REC_W{1'b1}}, 1'b0);
        add_result(assignment_of({REC_W{1'b1}}, 0, 1'b1));
        add_point(TS_MIN, 1, 1'b0);
        add_result(assignment_of(1, 0, 1'b1));
        add_point(TS_MAX, 2, 1'b1);
        // A new stream after a final point; two points in slot zero.
        add_point(0, 3, 1'b0);
        add_result(assignment_of(3, 0, 1'b1));
        add_point(599, 4, 1'b1);
        add_result(assignment_of(4, 0, 1'b0));
        add_result(descriptor_of(0, 0, 599, 2, 1, 0, 0, 0, 1'b1));
        // Just below zero lands in slot minus one.
        add_point(-1, 5, 1'b1);
        add_result(assignment_of(5, 0, 1'b0));
        add_result(descriptor_of(0, -1, -1, 1, 1, -1, -1, 0, 1'b1));

        // All registers zero: they act as one, so every bucket holds one
        // point. A repeat of the same time is a forced split; the last point
        // closes one bucket by the limit and one by being final.
        add_config('{slot_seconds: '0, target_records: '0, rec_limit: '0,
                     slot_limit: '0});
        add_point(7, 10, 1'b0);
        add_result(assignment_of(10, 0, 1'b1));
        add_point(7, 11, 1'b0);
        add_result(descriptor_of(0, 7, 7, 1, 1, 7, 7, 1, 1'b0));
        add_result(assignment_of(11, 1, 1'b1));
        add_point(8, 12, 1'b1);
        add_result(descriptor_of(1, 7, 7, 1, 1, 7, 7, 1, 1'b0));
        add_result(assignment_of(12, 2, 1'b0));
        add_result(descriptor_of(2, 8, 8, 1, 1, 8, 8, 1, 1'b1));

        // Target above the hard limit, so the target is the real cap. Times
        // cross zero through negative slots and pile up in one slot.
        add_config('{slot_seconds: SLOT_SEC_W'(10), target_records: LIMIT_W'(3),
                     rec_limit: LIMIT_W'(2), slot_limit: LIMIT_W'(2)});
        add_point(-25, 100, 1'b0);
        add_point(-21, 101, 1'b0);
        add_point(-20, 102, 1'b0);
        add_point(-11, 103, 1'b0);
        add_point(-10, 104, 1'b0);
        add_point(0, 105, 1'b0);
        add_point(0, 106, 1'b0);
        add_point(0, 107, 1'b0);
        add_point(0, 108, 1'b0);
        add_point(5, 109, 1'b0);
        add_point(9, 110, 1'b0);
        add_point(10, 111, 1'b0);
        add_point(30, 112, 1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
                load_config(plan[i].cfg);
            else
            begin
                for (int k = 0; k < plan[i].n_typed; k++)
                    typed_results.insert(typed_results.size(), plan[i].typed[k]);
                send_point(plan[i].pt);
            end
        end

        // Random part, checked against the predictor.
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            load_config(rand_config(phase));
            while (sent < (phase + 1) * RAND_ITEMS / RAND_PHASES)
                send_stream($urandom_range(0, 99) < 15, sent);
        end

        push <= 1'b0;
        while (awaited_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
